/* sv/idru_pkg.sv */
// Shared types and constants for the integer divide / remainder unit.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package idru_pkg;

    // Port width of the operand and result words
    localparam int RES_W = 64;

    // Request type codes
    typedef enum logic [1:0] {
        OP_UDIV = 2'd0,
        OP_UREM = 2'd1,
        OP_SDIV = 2'd2,
        OP_SREM = 2'd3
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the request word
        logic setup;    // take magnitudes, clear partial remainder
        logic step;     // one restoring shift-subtract step
        logic finish;   // sign fix-up, load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_step;    // current step produces the final quotient bit
    } t_sts;

endpackage

/* sv/idru_ctrl.sv */
// Sequencing state machine and result-valid flag of the divide unit.
// Depends on idru_pkg (command and status structs).
`timescale 1ns / 1ps

module idru_ctrl
    import idru_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_FIX   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // Result register can take a new word when empty or being drained
    assign w_out_free = !r_out_valid || i_ready;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // hold here while the previous result is still waiting
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set valid on a new result, drop it when the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A result is never written over an unread one
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while full");

    // A captured request is set up in the following cycle
    a_load_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.setup)
        else $error("setup did not follow load");

    // No new word is taken while a division is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!o_cmd.step && !o_cmd.finish && !o_cmd.setup))
        else $error("input ready during division");

    // The final step leads to the fix-up cycle
    a_last_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.last_step) |=> (r_state == S_FIX))
        else $error("last step did not reach fix-up");

endmodule

/* sv/idru_dpath.sv */
// Restoring shift-subtract datapath: operand capture, sign handling, one
// quotient bit per step, fix-up and result register. Depends on idru_pkg.
`timescale 1ns / 1ps

module idru_dpath
    import idru_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [1:0]       i_req_type,
    input  logic [RES_W-1:0] i_dividend,
    input  logic [RES_W-1:0] i_divisor,
    output logic [RES_W-1:0] o_result
);

    localparam int CNT_W = $clog2(WIDTH);

    t_op              r_op;
    logic [WIDTH-1:0] r_num;    // dividend magnitude, shifts into quotient
    logic [WIDTH-1:0] r_den;    // divisor magnitude
    logic [WIDTH-1:0] r_rem;    // partial remainder
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg_q;
    logic             r_neg_r;
    logic             r_zero;
    logic [RES_W-1:0] r_result;

    logic             w_signed;
    logic             w_is_rem;
    logic             w_sn;
    logic             w_sd;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_qbit;
    logic [WIDTH-1:0] w_quo;
    logic [WIDTH-1:0] w_rem;

    assign w_signed = (r_op == OP_SDIV) || (r_op == OP_SREM);
    assign w_is_rem = (r_op == OP_UREM) || (r_op == OP_SREM);
    assign w_sn     = w_signed && r_num[WIDTH-1];
    assign w_sd     = w_signed && r_den[WIDTH-1];

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_num[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_qbit  = !w_diff[WIDTH];

    // Sign fix-up; a zero divisor gives quotient 0 and remainder 0 or the dividend
    assign w_quo = r_zero ? '0 : (r_neg_q ? ('0 - r_num) : r_num);
    assign w_rem = (r_zero && !w_signed) ? '0 : (r_neg_r ? ('0 - r_rem) : r_rem);

    assign o_sts.last_step = (r_cnt == CNT_W'(WIDTH - 1));
    assign o_result        = r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_req_type);
            r_num <= i_dividend[WIDTH-1:0];
            r_den <= i_divisor[WIDTH-1:0];
        end else if (i_cmd.setup) begin
            r_num   <= w_sn ? ('0 - r_num) : r_num;
            r_den   <= w_sd ? ('0 - r_den) : r_den;
            r_neg_q <= w_sn ^ w_sd;
            r_neg_r <= w_sn;
            r_zero  <= (r_den == '0);
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            // advance one quotient bit, restore on a negative trial
            r_rem <= w_qbit ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            r_num <= {r_num[WIDTH-2:0], w_qbit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Result register, zero above the word width
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= RES_W'(w_is_rem ? w_rem : w_quo);
        end
    end

    // Unsigned division by zero always yields zero
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_zero && !w_signed) |=> (o_result == '0))
        else $error("unsigned divide by zero gave nonzero result");

endmodule

/* sv/integer_divide_remainder_unit.sv */
// Top level of the integer divide / remainder unit: controller plus datapath.
// Depends on idru_pkg, idru_ctrl and idru_dpath.
//
//   channel   direction   handshake            payload
//   request   in          i_valid / o_ready    i_req_type, i_dividend, i_divisor
//   result    out         o_valid / i_ready    o_result
//
// A request occupies the unit from its accept cycle through a setup step for
// operand magnitudes, WIDTH restoring steps through a single (WIDTH+1)-bit
// subtractor, and a sign fix-up step.
// The result register lets a new request enter while the last result waits.
// Fix-up stalls while the result register still holds an unread word.
// Reset is synchronous, active low; it empties the result register.
`timescale 1ns / 1ps

module integer_divide_remainder_unit
    import idru_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  logic [RES_W-1:0] i_dividend,
    input  logic [RES_W-1:0] i_divisor,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    idru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    idru_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_result   (o_result)
    );

endmodule

/* tb/integer_divide_remainder_unit_test.sv */
// Self-checking testbench for the integer divide / remainder unit.
// Depends on idru_pkg and integer_divide_remainder_unit; predicts each result word
// from the request and compares it with the word the unit returns.
`timescale 1ns / 1ps

module integer_divide_remainder_unit_test;
    import idru_pkg::*;

    localparam int          TIMEOUT_CYCLES = 1500000;
    localparam int          TAIL_CYCLES    = 3 * (RES_W + 3);
    localparam int          RANDOM_WORDS   = 700;
    localparam logic [RES_W-1:0] MOST_NEG  = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] MOST_POS  = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] ALL_ONES  = {RES_W{1'b1}};

    // One request word plus pacing hints for the driver
    typedef struct {
        t_op              op;
        logic [RES_W-1:0] dividend;
        logic [RES_W-1:0] divisor;
        logic             wait_drain;   // hold until every result is back
        logic             back_to_back; // no gap after this word
    } t_div_request;

    // One predicted result word, kept with its request for the report
    typedef struct {
        logic [RES_W-1:0] value;
        t_op              op;
        logic [RES_W-1:0] dividend;
        logic [RES_W-1:0] divisor;
    } t_div_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    t_op              i_req_type = OP_UDIV;
    logic [RES_W-1:0] i_dividend = '0;
    logic [RES_W-1:0] i_divisor = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [RES_W-1:0] o_result;

    t_div_request pending_requests[$];
    t_div_answer  expected_answers[$];
    t_div_answer  sent_answer;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_gap_left = 0;
    int           ready_stall_left = 0;

    integer_divide_remainder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Quotient or remainder of one request; signed forms divide magnitudes
    function automatic logic [RES_W-1:0] divide_result(t_op op, logic [RES_W-1:0] n,
                                                       logic [RES_W-1:0] d);
        logic             neg_n;
        logic             neg_d;
        logic [RES_W-1:0] mag_n;
        logic [RES_W-1:0] mag_d;
        logic [RES_W-1:0] quo;
        neg_n = n[RES_W-1];
        neg_d = d[RES_W-1];
        case (op)
            OP_UDIV: begin
                return (d == '0) ? '0 : n / d;
            end
            OP_UREM: begin
                return (d == '0) ? '0 : n % d;
            end
            default: begin
                mag_n = neg_n ? -n : n;
                mag_d = neg_d ? -d : d;
                quo   = (mag_d == '0) ? '0 : mag_n / mag_d;
                if (neg_n != neg_d) begin
                    quo = -quo;
                end
                // remainder wraps modulo 2^RES_W, so it keeps the dividend's sign
                return (op == OP_SDIV) ? quo : n - quo * d;
            end
        endcase
    endfunction

    function automatic logic [RES_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Random word of random bit length, sometimes negated
    function automatic logic [RES_W-1:0] random_scaled_word();
        logic [RES_W-1:0] w;
        w = random_word() >> $urandom_range(0, RES_W - 1);
        return ($urandom_range(0, 1) != 0) ? -w : w;
    endfunction

    function automatic logic [RES_W-1:0] special_word();
        case ($urandom_range(0, 5))
            0:       return MOST_NEG;
            1:       return ALL_ONES;
            2:       return '0;
            3:       return RES_W'(1);
            4:       return MOST_POS;
            default: return random_word();
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 200);
    endfunction

    task automatic report_mismatch(string what, t_div_answer a, logic [RES_W-1:0] got);
        mismatch_count++;
        $display("[%0d] %s: op %s dividend %h divisor %h expected %h got %h",
                 cycle_count, what, a.op.name(), a.dividend, a.divisor, a.value, got);
    endtask

    task automatic queue_request(t_op op, logic [RES_W-1:0] n, logic [RES_W-1:0] d,
                                 logic wait_drain, logic back_to_back);
        t_div_request r;
        r.op           = op;
        r.dividend     = n;
        r.divisor      = d;
        r.wait_drain   = wait_drain;
        r.back_to_back = back_to_back;
        pending_requests.push_back(r);
    endtask

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Request driver: predict on accept, then hold, idle or present the next word
    always @(posedge i_clk) begin
        t_div_request nxt;
        t_div_answer  ans;
        logic         accepted;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            send_gap_left <= 0;
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) begin
                ans          = sent_answer;
                ans.value    = divide_result(ans.op, ans.dividend, ans.divisor);
                expected_answers.push_back(ans);
            end
            if (i_valid && !accepted) begin
                // hold the word until it is taken
            end else if (send_gap_left != 0) begin
                send_gap_left <= send_gap_left - 1;
                i_valid       <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].wait_drain && expected_answers.size() != 0)) begin
                nxt                  = pending_requests.pop_front();
                i_valid              <= 1'b1;
                i_req_type           <= nxt.op;
                i_dividend           <= nxt.dividend;
                i_divisor            <= nxt.divisor;
                sent_answer.op       = nxt.op;
                sent_answer.dividend = nxt.dividend;
                sent_answer.divisor  = nxt.divisor;
                send_gap_left        <= nxt.back_to_back ? 0 : pick_idle();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted word, then pick the next stall
    always @(posedge i_clk) begin
        t_div_answer want;
        if (!i_rst_n) begin
            i_ready          <= 1'b0;
            ready_stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    want = '{value: '0, op: OP_UDIV, dividend: '0, divisor: '0};
                    report_mismatch("result with nothing expected", want, o_result);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_result !== want.value) begin
                        report_mismatch("result mismatch", want, o_result);
                    end
                end
            end
            if (ready_stall_left != 0) begin
                ready_stall_left <= ready_stall_left - 1;
                i_ready          <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                // every fourth window of the cycle count runs without stalls
                ready_stall_left <= ((cycle_count / 5000) % 4 == 1) ? 0 : pick_idle();
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [RES_W-1:0] pair_n[6];
        logic [RES_W-1:0] pair_d[6];
        logic [RES_W-1:0] n;
        logic [RES_W-1:0] d;
        t_op              op;
        logic             burst;

        // Directed: every operation against the corner operand pairs
        pair_n = '{MOST_NEG, -64'sd9, ALL_ONES, MOST_POS, -64'sd7, '0};
        pair_d = '{ALL_ONES, '0, RES_W'(1), MOST_NEG, RES_W'(2), ALL_ONES};
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 4; k++) begin
                queue_request(t_op'(k), pair_n[p], pair_d[p], 1'b0, 1'b0);
            end
        end

        // Random: mix of operand shapes, with drain points and gap-free bursts
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            op    = t_op'($urandom_range(0, 3));
            burst = (i >= 200 && i < 260) || (i >= 500 && i < 540);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = random_word();
                    d = random_word();
                end
                3: begin
                    n = random_word();
                    d = random_scaled_word();
                end
                4: begin
                    n = random_word();
                    d = RES_W'($urandom_range(1, 255));
                    if ($urandom_range(0, 1) != 0) d = -d;
                end
                5: begin
                    n = random_scaled_word();
                    d = random_scaled_word();
                end
                6: begin
                    n = random_scaled_word();
                    d = '0;
                end
                7: begin
                    n = special_word();
                    d = special_word();
                end
                8: begin
                    n = random_word();
                    d = n >> $urandom_range(0, RES_W - 1);
                end
                default: begin
                    d = random_word();
                    n = d >> $urandom_range(1, RES_W - 1);
                end
            endcase
            queue_request(op, n, d, (i == 0 || i == 350), burst);
        end

        // Hold reset, then release
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain all words, then let the pipeline settle
        while (pending_requests.size() != 0 || i_valid || expected_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/idru_pkg.sv
sv/idru_ctrl.sv
sv/idru_dpath.sv
sv/integer_divide_remainder_unit.sv
tb/integer_divide_remainder_unit_test.sv
